### design/arxsd_pkg.sv
`default_nettype none
package arxsd_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 6;
	localparam int NUM_WORDS = 16;
	localparam int CFG_IDX_W = 3;
	localparam int TAG_BYTES = 16;
	localparam logic [63:0] INIT_MULT = 64'h7477697468617369;
	localparam logic [7:0] NEWLINE = 8'd10;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_DATA = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_TAG = 2'd1;
	localparam logic [1:0] KIND_TERM = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = 3'd6;

	typedef logic [63:0] word_t;
	typedef logic [NUM_WORDS-1:0][63:0] state_t;
	typedef logic [3:0][63:0] quad_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] data;
	} q_item_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [1:0][63:0] nonce;
		logic decrypt;
	} cfg_t;

	typedef struct packed {
		logic perm;
		logic stopped;
	} back_stat_t;

	function automatic word_t rotr(input word_t v, input int unsigned n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic quad_t quarter(input quad_t q);
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		a = q[0];
		b = q[1];
		c = q[2];
		d = q[3];
		a = a + b;
		d = rotr(d ^ a, 32);
		c = c + d;
		b = rotr(b ^ c, 25);
		a = a + b;
		d = rotr(d ^ a, 16);
		c = c + d;
		b = rotr(b ^ c, 11);
		return {d, c, b, a};
	endfunction

endpackage
`default_nettype wire

### design/arxsd_ifs.sv
`default_nettype none
interface arxsd_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	modport source(output valid, output cmd, output data_byte, input ready);
	modport sink(input valid, input cmd, input data_byte, output ready);
endinterface

interface arxsd_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic last;
	modport source(output valid, output out_byte, output kind, output last, input ready);
	modport sink(input valid, input out_byte, input kind, input last, output ready);
endinterface

interface arxsd_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [63:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### design/arxsd_front.sv
`default_nettype none
module arxsd_front (
	input wire logic clk,
	input wire logic arst_n,
	arxsd_in_if.sink item,
	output arxsd_pkg::q_item_t q_head,
	output logic q_valid,
	input wire logic pop
);
	import arxsd_pkg::*;

	q_item_t ent_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic keep;
	logic push;
	q_item_t new_item;

	always_comb begin
		keep = 1'b1;
		new_item.data = item.data_byte;
		case (item.cmd)
			CMD_START: new_item.op = OP_START;
			CMD_DATA: new_item.op = OP_DATA;
			CMD_FINISH: new_item.op = OP_FINISH;
			default: begin
				new_item.op = OP_START;
				keep = 1'b0;
			end
		endcase
	end

	assign item.ready = (cnt_q != 2'd2);
	assign push = item.valid && item.ready && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= new_item;
		end
	end

endmodule
`default_nettype wire

### design/arxsd_round.sv
`default_nettype none
module arxsd_round (
	input wire arxsd_pkg::state_t st_in,
	input wire logic diag,
	output arxsd_pkg::state_t st_out
);
	import arxsd_pkg::*;

	quad_t qi [4];
	quad_t qo [4];

	for (genvar k = 0; k < 4; k++) begin : g_lane
		assign qi[k] = diag
			? {st_in[12 + ((k + 3) % 4)], st_in[8 + ((k + 2) % 4)],
				st_in[4 + ((k + 1) % 4)], st_in[k]}
			: {st_in[12 + k], st_in[8 + k], st_in[4 + k], st_in[k]};
		assign qo[k] = quarter(qi[k]);
		assign st_out[k] = qo[k][0];
		assign st_out[4 + k] = diag ? qo[(k + 3) % 4][1] : qo[k][1];
		assign st_out[8 + k] = diag ? qo[(k + 2) % 4][2] : qo[k][2];
		assign st_out[12 + k] = diag ? qo[(k + 1) % 4][3] : qo[k][3];
	end

endmodule
`default_nettype wire

### design/arxsd_back.sv
`default_nettype none
module arxsd_back #(
	parameter int DOUBLE_ROUNDS = arxsd_pkg::DOUBLE_ROUNDS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire arxsd_pkg::cfg_t cfg_regs,
	input wire arxsd_pkg::q_item_t q_head,
	input wire logic q_valid,
	output logic pop,
	output arxsd_pkg::back_stat_t stat,
	arxsd_out_if.source result
);
	import arxsd_pkg::*;

	localparam int HALF = 2 * DOUBLE_ROUNDS;
	localparam int CNT_W = (HALF > 2) ? $clog2(HALF) : 1;
	localparam logic [CNT_W-1:0] HR_LAST = CNT_W'(HALF - 1);
	localparam logic [CNT_W-1:0] HR_ONE = CNT_W'(1);
	localparam logic [3:0] TAG_LAST = 4'(TAG_BYTES - 1);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PERM = 3'b010,
		PH_TAG = 3'b100
	} phase_t;

	phase_t phase_q;
	state_t st_q;
	logic stopped_q;
	logic [CNT_W-1:0] hr_q;
	logic fin_q;
	logic [3:0] tag_q;
	logic ov_q;
	logic [7:0] ob_q;
	logic [1:0] ok_q;
	logic ol_q;

	state_t init_st;
	state_t pre_st;
	state_t rnd_in;
	state_t rnd_out;
	logic rnd_diag;
	logic out_free;
	logic [7:0] dec_byte;
	logic is_term;
	logic run;
	word_t tag_word;
	logic [7:0] tag_byte;

	assign init_st[0] = cfg_regs.key[0];
	assign init_st[1] = cfg_regs.key[1];
	assign init_st[2] = cfg_regs.key[2];
	assign init_st[3] = cfg_regs.key[3];
	assign init_st[4] = cfg_regs.nonce[0];
	assign init_st[5] = cfg_regs.nonce[1];
	for (genvar k = 6; k < NUM_WORDS; k++) begin : g_init
		assign init_st[k] = 64'(INIT_MULT * 64'(k));
	end

	assign out_free = !ov_q || result.ready;
	assign pop = (phase_q == PH_IDLE) && q_valid && out_free;
	assign dec_byte = st_q[0][7:0] ^ q_head.data;
	assign is_term = cfg_regs.decrypt && (dec_byte == NEWLINE);

	always_comb begin
		pre_st = st_q;
		run = 1'b0;
		case (q_head.op)
			OP_START: begin
				pre_st = init_st;
				run = 1'b1;
			end
			OP_DATA: begin
				pre_st[0][7:0] = cfg_regs.decrypt ? q_head.data : dec_byte;
				run = !stopped_q && !is_term;
			end
			OP_FINISH: begin
				pre_st[0] = st_q[0] ^ 64'd1;
				run = !stopped_q;
			end
			default: run = 1'b0;
		endcase
	end

	assign rnd_in = (phase_q == PH_PERM) ? st_q : pre_st;
	assign rnd_diag = (phase_q == PH_PERM) ? hr_q[0] : 1'b0;

	arxsd_round u_round (
		.st_in(rnd_in),
		.diag(rnd_diag),
		.st_out(rnd_out)
	);

	assign tag_word = tag_q[3] ? (st_q[6] ^ st_q[7]) : (st_q[4] ^ st_q[5]);
	assign tag_byte = tag_word[{tag_q[2:0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			stopped_q <= 1'b1;
			hr_q <= '0;
			fin_q <= 1'b0;
			tag_q <= 4'd0;
			ov_q <= 1'b0;
		end else begin
			if (result.ready) begin
				ov_q <= 1'b0;
			end
			case (phase_q)
				PH_IDLE: begin
					if (pop) begin
						if (q_head.op == OP_START) begin
							stopped_q <= 1'b0;
						end
						if (q_head.op == OP_DATA && !stopped_q) begin
							ov_q <= 1'b1;
							if (is_term) begin
								stopped_q <= 1'b1;
							end
						end
						if (run) begin
							phase_q <= PH_PERM;
							hr_q <= HR_ONE;
							fin_q <= (q_head.op == OP_FINISH);
						end
					end
				end
				PH_PERM: begin
					if (hr_q == HR_LAST) begin
						tag_q <= 4'd0;
						if (fin_q) begin
							phase_q <= PH_TAG;
							stopped_q <= 1'b1;
						end else begin
							phase_q <= PH_IDLE;
						end
					end else begin
						hr_q <= hr_q + HR_ONE;
					end
				end
				PH_TAG: begin
					if (out_free) begin
						ov_q <= 1'b1;
						tag_q <= tag_q + 4'd1;
						if (tag_q == TAG_LAST) begin
							phase_q <= PH_IDLE;
						end
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((phase_q == PH_PERM) || (pop && run)) begin
			st_q <= rnd_out;
		end
		if (pop && q_head.op == OP_DATA && !stopped_q) begin
			ob_q <= is_term ? 8'd0 : dec_byte;
			ok_q <= is_term ? KIND_TERM : KIND_DATA;
			ol_q <= is_term;
		end else if (phase_q == PH_TAG && out_free) begin
			ob_q <= tag_byte;
			ok_q <= KIND_TAG;
			ol_q <= (tag_q == TAG_LAST);
		end
	end

	assign result.valid = ov_q;
	assign result.out_byte = ob_q;
	assign result.kind = ok_q;
	assign result.last = ol_q;

	assign stat.perm = (phase_q == PH_PERM);
	assign stat.stopped = stopped_q;

endmodule
`default_nettype wire

### design/arx_sponge_duplex_byte_cipher_core.sv
// Duplex sponge byte cipher with a 16 by 64-bit state and an ARX permutation.
// Configuration words on cfg set the key, the nonce and the decrypt mode. The user
// must write them while the core is idle; the core itself does not enforce this. The next start loads key and nonce.
// Each input word on item carries a command (start, data, finish) and a data
// byte; a command code of three is dropped. Accepted words go into a
// two-entry queue, and the engine takes them from it one at a time.
// A start word, or a data word that is not stopped and does not end the message,
// runs the permutation in the engine: one half-round of four quarter functions per
// cycle, two half-rounds per double round. A data word shows its result on result
// in the cycle after the engine takes it. A finish word runs the permutation, then
// 16 tag bytes, one per cycle while result is ready; the last tag byte carries last.
// In decrypt mode a decrypted newline gives one termination word with last
// set and stops the message until the next start.
// After reset the core is stopped: data and finish words are consumed with
// no result until a start arrives. A stalled result holds its output register
// and the engine waits, while the queue keeps accepting up to two words.
`default_nettype none
module arx_sponge_duplex_byte_cipher_core #(
	parameter int DOUBLE_ROUNDS = arxsd_pkg::DOUBLE_ROUNDS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	arxsd_cfg_if.sink cfg,
	arxsd_in_if.sink item,
	arxsd_out_if.source result
);
	import arxsd_pkg::*;

	cfg_t cfg_q;
	q_item_t q_head;
	logic q_valid;
	logic pop;
	back_stat_t stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KEY0: cfg_q.key[0] <= cfg.data;
				REG_KEY1: cfg_q.key[1] <= cfg.data;
				REG_KEY2: cfg_q.key[2] <= cfg.data;
				REG_KEY3: cfg_q.key[3] <= cfg.data;
				REG_NONCE0: cfg_q.nonce[0] <= cfg.data;
				REG_NONCE1: cfg_q.nonce[1] <= cfg.data;
				REG_DECRYPT: cfg_q.decrypt <= cfg.data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	arxsd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.q_head(q_head),
		.q_valid(q_valid),
		.pop(pop)
	);

	arxsd_back #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_q),
		.q_head(q_head),
		.q_valid(q_valid),
		.pop(pop),
		.stat(stat),
		.result(result)
	);

	a_pop_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("engine took a word from an empty queue");

	a_no_pop_in_perm: assert property (@(posedge clk) disable iff (!arst_n)
		stat.perm |-> !pop)
		else $error("engine took a word while permuting");

	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind == KIND_TERM) |-> (result.last && stat.stopped))
		else $error("termination word without last or without stop");

	a_tag_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind == KIND_TAG && result.last) |-> stat.stopped)
		else $error("message not stopped while the final tag byte is shown");

endmodule
`default_nettype wire
